// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps

package rau_pkg;

   localparam int unsigned CMD_WIDTH = 3;
   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned MAG_WIDTH = 64;
   localparam int unsigned SHIFT_WIDTH = 7;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_INC = 3'd4,
      CMD_DEC = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_COMBINE,
      ST_GCD_INIT,
      ST_GCD_PAIR,
      ST_GCD_U,
      ST_GCD_LOOP,
      ST_GCD_DONE,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 neg;
      logic [MAG_WIDTH-1:0] mag;
   } smag_type;

endpackage

// File: rtl/rational_arith_unit.sv
`timescale 1ns / 1ps

// Rational arithmetic unit. Each transaction carries a command and two fractions; the
// unit forms the exact numerator and denominator of a+b, a-b, a*b, a/b, a+1 or a-1 in
// 64-bit sign-magnitude form, then divides both by the gcd of their magnitudes, keeping
// signs as computed. Only one transaction is in flight: req_stall is high from acceptance
// until the result has been taken. One 32x32 multiplier forms the three products in
// turn, a binary gcd loop runs on one 64-bit subtractor, and the two divisions by the
// gcd run bit-serially on one shared restoring divider. Both parts 0 gives 0/0 with
// undefined_flag; overflow_flag marks a reduced part outside the signed OPERAND_WIDTH-bit
// range, and then the low 32 bits are given.
module rational_arith_unit #(
   parameter int unsigned OPERAND_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_res_num,
   output logic signed [31:0] rsp_res_den,
   output logic        rsp_undefined_flag,
   output logic        rsp_overflow_flag
);

   localparam int unsigned MW = rau_pkg::MAG_WIDTH;
   localparam int unsigned SW = rau_pkg::SHIFT_WIDTH;
   localparam logic [MW-1:0] LIMIT = MW'(1) << (OPERAND_WIDTH - 1);

   rau_pkg::state_type state_ff, state_in;

   logic [2:0]           cmd_ff, cmd_in;
   rau_pkg::smag_type    an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   rau_pkg::smag_type    p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   rau_pkg::smag_type    num_ff, num_in, den_ff, den_in;
   logic [MW-1:0]        u_ff, u_in, v_ff, v_in;
   logic [SW-1:0]        shift_ff, shift_in;
   logic [MW-1:0]        g_ff, g_in;
   // Shared restoring divider: quotient shifts into q, remainder in r.
   logic [MW-1:0]        q_ff, q_in, r_ff, r_in;
   logic [SW-1:0]        cnt_ff, cnt_in;
   logic                 undef_ff, undef_in;
   logic [31:0]          res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic                 ovf_ff, ovf_in;

   // Shared multiplier operands.
   rau_pkg::smag_type    mx, my, mprod;
   // Shared subtractor.
   logic [MW-1:0]        sub_a, sub_b, sub_d;
   logic                 sub_ge;
   logic [MW:0]          rem_shift;

   function automatic rau_pkg::smag_type load_op(input logic [OPERAND_WIDTH-1:0] raw);
      rau_pkg::smag_type r;
      logic [OPERAND_WIDTH-1:0] negv;
      negv  = ~raw + OPERAND_WIDTH'(1);
      r.neg = raw[OPERAND_WIDTH-1];
      r.mag = r.neg ? MW'(negv) : MW'(raw);
      if (r.neg && raw == {1'b1, {(OPERAND_WIDTH-1){1'b0}}}) begin
         r.mag = LIMIT;
      end
      return r;
   endfunction

   function automatic rau_pkg::smag_type sm_add(input rau_pkg::smag_type x,
                                                input rau_pkg::smag_type y);
      rau_pkg::smag_type r;
      if (x.neg == y.neg) begin
         r.mag = x.mag + y.mag;
         r.neg = x.neg;
      end else if (x.mag >= y.mag) begin
         r.mag = x.mag - y.mag;
         r.neg = x.neg;
      end else begin
         r.mag = y.mag - x.mag;
         r.neg = y.neg;
      end
      if (r.mag == '0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

   function automatic rau_pkg::smag_type sm_neg(input rau_pkg::smag_type x);
      rau_pkg::smag_type r;
      r = x;
      if (x.mag != '0) begin
         r.neg = ~x.neg;
      end
      return r;
   endfunction

   function automatic logic out_of_range(input rau_pkg::smag_type x);
      return x.neg ? (x.mag > LIMIT) : (x.mag > LIMIT - MW'(1));
   endfunction

   function automatic logic [31:0] to_field(input rau_pkg::smag_type x);
      logic [MW-1:0] v;
      v = x.neg ? (MW'(0) - x.mag) : x.mag;
      return v[31:0];
   endfunction

   // Multiplier: operands are at most 2^(OPERAND_WIDTH-1), which fits 32 bits.
   always_comb begin
      mx = an_ff;
      my = bd_ff;
      unique case (state_ff)
         rau_pkg::ST_MUL0: begin
            mx = an_ff;
            my = (cmd_ff == rau_pkg::CMD_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::ST_MUL1: begin
            mx = bn_ff;
            my = ad_ff;
         end
         rau_pkg::ST_MUL2: begin
            mx = ad_ff;
            my = (cmd_ff == rau_pkg::CMD_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mx = an_ff;
            my = bd_ff;
         end
      endcase
      mprod.mag = mx.mag[31:0] * my.mag[31:0];
      mprod.neg = (mprod.mag != '0) && (mx.neg != my.neg);
   end

   // Subtractor shared by the gcd loop and the divider.
   always_comb begin
      rem_shift = {r_ff, q_ff[MW-1]};
      if (state_ff == rau_pkg::ST_DIV_NUM || state_ff == rau_pkg::ST_DIV_DEN) begin
         sub_a = rem_shift[MW-1:0];
         sub_b = g_ff;
      end else begin
         sub_a = (u_ff > v_ff) ? u_ff : v_ff;
         sub_b = (u_ff > v_ff) ? v_ff : u_ff;
      end
      sub_d  = sub_a - sub_b;
      sub_ge = rem_shift[MW] || (sub_a >= sub_b);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rau_pkg::ST_MUL0;
            end
         end
         rau_pkg::ST_MUL0:     state_in = rau_pkg::ST_MUL1;
         rau_pkg::ST_MUL1:     state_in = rau_pkg::ST_MUL2;
         rau_pkg::ST_MUL2:     state_in = rau_pkg::ST_COMBINE;
         rau_pkg::ST_COMBINE:  state_in = rau_pkg::ST_GCD_INIT;
         rau_pkg::ST_GCD_INIT: begin
            if (num_ff.mag == '0 && den_ff.mag == '0) begin
               state_in = rau_pkg::ST_FINISH;
            end else if (num_ff.mag == '0 || den_ff.mag == '0) begin
               state_in = rau_pkg::ST_GCD_DONE;
            end else begin
               state_in = rau_pkg::ST_GCD_PAIR;
            end
         end
         rau_pkg::ST_GCD_PAIR: begin
            if (u_ff[0] || v_ff[0]) begin
               state_in = rau_pkg::ST_GCD_U;
            end
         end
         rau_pkg::ST_GCD_U: begin
            if (u_ff[0]) begin
               state_in = rau_pkg::ST_GCD_LOOP;
            end
         end
         rau_pkg::ST_GCD_LOOP: begin
            if (v_ff == '0) begin
               state_in = rau_pkg::ST_GCD_DONE;
            end
         end
         rau_pkg::ST_GCD_DONE: state_in = rau_pkg::ST_DIV_NUM;
         rau_pkg::ST_DIV_NUM: begin
            if (cnt_ff == SW'(MW - 1)) begin
               state_in = rau_pkg::ST_DIV_DEN;
            end
         end
         rau_pkg::ST_DIV_DEN: begin
            if (cnt_ff == SW'(MW - 1)) begin
               state_in = rau_pkg::ST_FINISH;
            end
         end
         rau_pkg::ST_FINISH:   state_in = rau_pkg::ST_OUT;
         rau_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = rau_pkg::ST_IDLE;
            end
         end
         default:              state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      rau_pkg::smag_type zero;
      zero       = '0;
      cmd_in     = cmd_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      shift_in   = shift_ff;
      g_in       = g_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      cnt_in     = cnt_ff;
      undef_in   = undef_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      ovf_in     = ovf_ff;
      unique case (state_ff)
         rau_pkg::ST_IDLE: begin
            cmd_in = req_cmd;
            an_in  = load_op(req_a_num[OPERAND_WIDTH-1:0]);
            ad_in  = load_op(req_a_den[OPERAND_WIDTH-1:0]);
            bn_in  = load_op(req_b_num[OPERAND_WIDTH-1:0]);
            bd_in  = load_op(req_b_den[OPERAND_WIDTH-1:0]);
         end
         rau_pkg::ST_MUL0: p0_in = mprod;
         rau_pkg::ST_MUL1: p1_in = mprod;
         rau_pkg::ST_MUL2: p2_in = mprod;
         rau_pkg::ST_COMBINE: begin
            case (cmd_ff) inside
               rau_pkg::CMD_ADD: begin
                  num_in = sm_add(p0_ff, p1_ff);
                  den_in = p2_ff;
               end
               rau_pkg::CMD_SUB: begin
                  num_in = sm_add(p0_ff, sm_neg(p1_ff));
                  den_in = p2_ff;
               end
               rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: begin
                  num_in = p0_ff;
                  den_in = p2_ff;
               end
               rau_pkg::CMD_INC: begin
                  num_in = sm_add(an_ff, ad_ff);
                  den_in = ad_ff;
               end
               rau_pkg::CMD_DEC: begin
                  num_in = sm_add(an_ff, sm_neg(ad_ff));
                  den_in = ad_ff;
               end
               default: begin
                  num_in = zero;
                  den_in = zero;
               end
            endcase
         end
         rau_pkg::ST_GCD_INIT: begin
            u_in     = num_ff.mag;
            v_in     = den_ff.mag;
            shift_in = '0;
            undef_in = (num_ff.mag == '0) && (den_ff.mag == '0);
            // With one part zero, the gcd is the other part.
            if (num_ff.mag == '0) begin
               u_in = den_ff.mag;
            end
         end
         rau_pkg::ST_GCD_PAIR: begin
            if (!(u_ff[0] || v_ff[0])) begin
               u_in     = u_ff >> 1;
               v_in     = v_ff >> 1;
               shift_in = shift_ff + SW'(1);
            end
         end
         rau_pkg::ST_GCD_U: begin
            if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end
         end
         rau_pkg::ST_GCD_LOOP: begin
            if (v_ff != '0) begin
               if (!v_ff[0]) begin
                  v_in = v_ff >> 1;
               end else begin
                  u_in = sub_b;
                  v_in = sub_d;
               end
            end
         end
         rau_pkg::ST_GCD_DONE: begin
            g_in   = u_ff << shift_ff;
            q_in   = num_ff.mag;
            r_in   = '0;
            cnt_in = '0;
         end
         rau_pkg::ST_DIV_NUM, rau_pkg::ST_DIV_DEN: begin
            r_in   = sub_ge ? sub_d : rem_shift[MW-1:0];
            q_in   = {q_ff[MW-2:0], sub_ge};
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff == SW'(MW - 1)) begin
               cnt_in = '0;
               r_in   = '0;
               if (state_ff == rau_pkg::ST_DIV_NUM) begin
                  num_in.mag = {q_ff[MW-2:0], sub_ge};
                  q_in       = den_ff.mag;
               end else begin
                  den_in.mag = {q_ff[MW-2:0], sub_ge};
               end
            end
         end
         rau_pkg::ST_FINISH: begin
            if (undef_ff) begin
               res_num_in = '0;
               res_den_in = '0;
               ovf_in     = 1'b0;
            end else begin
               res_num_in = to_field(num_ff);
               res_den_in = to_field(den_ff);
               ovf_in     = out_of_range(num_ff) || out_of_range(den_ff);
            end
         end
         rau_pkg::ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = (state_ff != rau_pkg::ST_IDLE);
      rsp_valid = (state_ff == rau_pkg::ST_OUT);
   end

   assign rsp_res_num        = res_num_ff;
   assign rsp_res_den        = res_den_ff;
   assign rsp_undefined_flag = undef_ff;
   assign rsp_overflow_flag  = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff     <= cmd_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      shift_ff   <= shift_in;
      g_ff       <= g_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      cnt_ff     <= cnt_in;
      undef_ff   <= undef_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      ovf_ff     <= ovf_in;
   end

   // A result is held until it has been taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_num))
      else $error("result changed while stalled");

   // A request is never taken while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted during response");

   // An undefined result is always 0/0 with no overflow.
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined_flag |-> rsp_res_num == 0 && rsp_res_den == 0
         && !rsp_overflow_flag)
      else $error("undefined result not zero");

   // The gcd is never zero once the division passes start.
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == rau_pkg::ST_DIV_NUM |-> g_ff != '0)
      else $error("division by zero gcd");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

// Checks the rational arithmetic unit against a behavioral predictor: one
// 64-bit sign-magnitude computation per transaction, gcd reduction, and
// range checks for the overflow flag.
module testbench;

   localparam int OPW = 32;
   localparam int NUM_RANDOM = 1500;
   localparam int WATCHDOG_LIMIT = 20000;

   // Expected result of one transaction.
   typedef struct {
      logic [31:0] res_num;
      logic [31:0] res_den;
      logic        undef_flag;
      logic        ovf_flag;
   } fraction_result;

   // Computes the reduced fraction for a transaction and checks results in order.
   class fraction_scoreboard;
      fraction_result pending[$];
      int errors;
      int checked;

      function void split(input logic [31:0] raw, output bit neg, output logic [63:0] mag);
         logic [63:0] v;
         v = {{32{raw[31]}}, raw};
         neg = raw[31];
         mag = neg ? -v : v;
      endfunction

      function void prod(input bit xn, input logic [63:0] xm, input bit yn,
                         input logic [63:0] ym, output bit rn, output logic [63:0] rm);
         rm = xm * ym;
         rn = (rm != 0) && (xn != yn);
      endfunction

      function void sum(input bit xn, input logic [63:0] xm, input bit yn,
                        input logic [63:0] ym, output bit rn, output logic [63:0] rm);
         if (xn == yn) begin
            rm = xm + ym;
            rn = xn;
         end else if (xm >= ym) begin
            rm = xm - ym;
            rn = xn;
         end else begin
            rm = ym - xm;
            rn = yn;
         end
         if (rm == 0) rn = 0;
      endfunction

      function logic [63:0] gcd64(input logic [63:0] u, input logic [63:0] v);
         logic [63:0] t;
         if (u == 0) return v;
         while (v != 0) begin
            t = u % v;
            u = v;
            v = t;
         end
         return u;
      endfunction

      function bit too_wide(input bit neg, input logic [63:0] mag);
         logic [63:0] lim;
         lim = 64'd1 << (OPW - 1);
         return neg ? (mag > lim) : (mag > lim - 1);
      endfunction

      function void note_request(input logic [2:0] cmd, input logic [31:0] an_raw,
                                 input logic [31:0] ad_raw, input logic [31:0] bn_raw,
                                 input logic [31:0] bd_raw);
         bit an_n, ad_n, bn_n, bd_n, pn, qn, nn, dn;
         logic [63:0] an_m, ad_m, bn_m, bd_m, pm, qm, nm, dm, g, tn, td;
         fraction_result r;
         split(an_raw, an_n, an_m);
         split(ad_raw, ad_n, ad_m);
         split(bn_raw, bn_n, bn_m);
         split(bd_raw, bd_n, bd_m);
         nn = 0; nm = 0; dn = 0; dm = 0;
         case (cmd) inside
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
               prod(an_n, an_m, bd_n, bd_m, pn, pm);
               prod(bn_n, bn_m, ad_n, ad_m, qn, qm);
               if (cmd == rau_pkg::CMD_SUB && qm != 0) qn = !qn;
               sum(pn, pm, qn, qm, nn, nm);
               prod(ad_n, ad_m, bd_n, bd_m, dn, dm);
            end
            rau_pkg::CMD_MUL: begin
               prod(an_n, an_m, bn_n, bn_m, nn, nm);
               prod(ad_n, ad_m, bd_n, bd_m, dn, dm);
            end
            rau_pkg::CMD_DIV: begin
               prod(an_n, an_m, bd_n, bd_m, nn, nm);
               prod(ad_n, ad_m, bn_n, bn_m, dn, dm);
            end
            rau_pkg::CMD_INC, rau_pkg::CMD_DEC: begin
               qn = ad_n;
               if (cmd == rau_pkg::CMD_DEC && ad_m != 0) qn = !qn;
               sum(an_n, an_m, qn, ad_m, nn, nm);
               dn = ad_n;
               dm = ad_m;
            end
            default: ;
         endcase
         if (nm == 0 && dm == 0) begin
            r = '{32'd0, 32'd0, 1'b1, 1'b0};
         end else begin
            g = gcd64(nm, dm);
            nm = nm / g;
            dm = dm / g;
            tn = nn ? -nm : nm;
            td = dn ? -dm : dm;
            r = '{tn[31:0], td[31:0], 1'b0, too_wide(nn, nm) || too_wide(dn, dm)};
         end
         pending.push_back(r);
      endfunction

      function void check_result(input logic [31:0] num, input logic [31:0] den,
                                 input logic undef_flag, input logic ovf_flag);
         fraction_result e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h/%h", $realtime, num, den);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (num !== e.res_num) begin
            $display("%0t: res_num expected %h actual %h", $realtime, e.res_num, num);
            errors++;
         end
         if (den !== e.res_den) begin
            $display("%0t: res_den expected %h actual %h", $realtime, e.res_den, den);
            errors++;
         end
         if (undef_flag !== e.undef_flag) begin
            $display("%0t: undefined_flag expected %b actual %b", $realtime,
                     e.undef_flag, undef_flag);
            errors++;
         end
         if (ovf_flag !== e.ovf_flag) begin
            $display("%0t: overflow_flag expected %b actual %b", $realtime,
                     e.ovf_flag, ovf_flag);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_cmd;
   logic signed [31:0] req_a_num, req_a_den, req_b_num, req_b_den;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_res_num, rsp_res_den;
   logic rsp_undefined_flag, rsp_overflow_flag;

   fraction_scoreboard fractions;
   bit quiet_phase;   // no idling on either side near the end of the run
   int sent;
   int idle_cycles;

   rational_arith_unit #(.OPERAND_WIDTH(OPW)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_a_num(req_a_num),
      .req_a_den(req_a_den),
      .req_b_num(req_b_num),
      .req_b_den(req_b_den),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den),
      .rsp_undefined_flag(rsp_undefined_flag),
      .rsp_overflow_flag(rsp_overflow_flag)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Inputs change only at the rising edge through nonblocking assignments,
   // and outputs are sampled at the same edge, so the sampled values are
   // the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         fractions.note_request(req_cmd, req_a_num, req_a_den, req_b_num, req_b_den);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         fractions.check_result(rsp_res_num, rsp_res_den, rsp_undefined_flag,
                                rsp_overflow_flag);
      end
   end

   // The receiver stalls at random, and each stall also ends at random.
   always @(posedge clock) begin
      if (reset || quiet_phase) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall) begin
         if ($urandom_range(0, 2) == 0) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
      end
   end

   // A transaction is offered after an optional random gap and held until it is taken.
   // Valid stays high from one transaction into the next unless a random gap drops it.
   task automatic send_fraction(input logic [2:0] cmd, input logic [31:0] an,
                                input logic [31:0] ad, input logic [31:0] bn,
                                input logic [31:0] bd);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         1: return 32'($signed($urandom_range(0, 8)) - 4);
         2: return 32'($urandom_range(0, 200)) * ($urandom_range(0, 1) ? -1 : 1);
         3: return 32'($urandom_range(0, 65535)) - 32'd32768;
         default: return $urandom();
      endcase
   endfunction

   // Ends the run if the block makes no progress for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d transactions", sent);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [2:0] c;
      logic [31:0] n1, d1, n2, d2;
      fractions = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_a_num = '0;
      req_a_den = '0;
      req_b_num = '0;
      req_b_den = '0;
      quiet_phase = 1'b0;
      sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each command, field extremes, zero parts and unused codes.
      send_fraction(rau_pkg::CMD_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
      send_fraction(rau_pkg::CMD_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);  // zero over nonzero
      send_fraction(rau_pkg::CMD_MUL, -32'sd6, 32'sd4, 32'sd2, -32'sd3);
      send_fraction(rau_pkg::CMD_DIV, 32'sd3, 32'sd5, 32'sd0, 32'sd7);  // nonzero over zero
      send_fraction(rau_pkg::CMD_INC, 32'sd5, -32'sd7, 32'sd9, 32'sd9);
      send_fraction(rau_pkg::CMD_DEC, -32'sd5, 32'sd7, 32'sd1, 32'sd1);
      send_fraction(rau_pkg::CMD_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0);  // both parts zero
      send_fraction(rau_pkg::CMD_MUL, 32'sd4, 32'sd0, 32'sd3, 32'sd5);  // zero denominator
      send_fraction(3'd6, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_fraction(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
      send_fraction(rau_pkg::CMD_MUL, 32'h8000_0000, 32'sd1, 32'h8000_0000, 32'sd1);
      send_fraction(rau_pkg::CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000);
      send_fraction(rau_pkg::CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h8000_0000);
      send_fraction(rau_pkg::CMD_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h8000_0000);
      send_fraction(rau_pkg::CMD_INC, 32'h7fff_ffff, 32'sd1, 32'sd0, 32'sd0);  // overflow
      send_fraction(rau_pkg::CMD_DEC, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd0);
      send_fraction(rau_pkg::CMD_INC, 32'sd3, 32'sd0, 32'sd0, 32'sd0);
      send_fraction(rau_pkg::CMD_DEC, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
      send_fraction(rau_pkg::CMD_DIV, 32'sd0, 32'sd5, 32'sd0, 32'sd3);          // both zero
      send_fraction(rau_pkg::CMD_ADD, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

      // Hold off the sender until the result queue drains.
      req_valid <= 1'b0;
      @(posedge clock);
      while (fractions.pending.size() != 0) @(posedge clock);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM - 100) quiet_phase = 1'b1;
         c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
         n1 = pick_value();
         d1 = pick_value();
         n2 = pick_value();
         d2 = pick_value();
         send_fraction(c, n1, d1, n2, d2);
      end
      req_valid <= 1'b0;

      while (fractions.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d transactions over all commands, unused codes, zero parts",
               sent);
      $display("and range extremes, with %0d results checked.", fractions.checked);
      if (fractions.errors == 0 && fractions.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/rau_pkg.sv
rtl/rational_arith_unit.sv
test/testbench.sv
